// ===== hdl/servo_settle_supervisor_unit_defines.svh =====
// Assertion macros used by the servo settle supervisor top level.
`ifndef SERVO_SETTLE_SUPERVISOR_UNIT_DEFINES_SVH
`define SERVO_SETTLE_SUPERVISOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sss_pkg.sv =====
// Types, codes and reset constants of the servo settle supervisor.
package sss_pkg;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_MOVING   = 3'd1,
    ST_SETTLING = 3'd2,
    ST_REACHED  = 3'd3,
    ST_ERROR    = 3'd4
  } state_e;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_START     = 3'd1,
    EV_NEAR      = 3'd2,
    EV_AT_TARGET = 3'd3,
    EV_DRIFT     = 3'd4,
    EV_TIMEOUT   = 3'd5,
    EV_ERROR     = 3'd6
  } event_e;

  typedef enum logic [3:0] {
    RS_NONE        = 4'd0,
    RS_START       = 4'd1,
    RS_NEAR        = 4'd2,
    RS_TIMEOUT     = 4'd3,
    RS_AT_TARGET   = 4'd4,
    RS_STABLE      = 4'd5,
    RS_RETRIES_EXC = 4'd6,
    RS_DRIFT_RETRY = 4'd7,
    RS_DRIFT       = 4'd8,
    RS_NEW_MOVE    = 4'd9,
    RS_ERROR_RESET = 4'd10
  } reason_e;

  typedef enum logic [1:0] {
    REG_TOLERANCE    = 2'd0,
    REG_SETTLE_MS    = 2'd1,
    REG_MOVE_TIMEOUT = 2'd2,
    REG_RETRY_LIMIT  = 2'd3
  } reg_e;

  localparam int unsigned AddrWidth = 4;

  localparam logic [14:0] TOLERANCE_RST    = 15'd5;
  localparam logic [15:0] SETTLE_MS_RST    = 16'd500;
  localparam logic [31:0] MOVE_TIMEOUT_RST = 32'd10000;
  localparam logic [7:0]  RETRY_LIMIT_RST  = 8'd3;

  typedef struct packed {
    logic              tick;
    logic [2:0]        event_code;
    logic              check_position;
    logic signed [15:0] pos_err;
  } item_t;

  typedef struct packed {
    logic [14:0] tolerance;
    logic [15:0] settle_ms;
    logic [31:0] move_timeout_ms;
    logic [7:0]  retry_limit;
  } cfg_t;

  typedef struct packed {
    state_e      fsm_state;
    state_e      last_state;
    logic [31:0] time_in_state;
    logic [7:0]  retry_cnt;
  } ctx_t;

  typedef struct packed {
    ctx_t    ctx;
    logic    changed;
    event_e  applied_event;
    reason_e reason;
  } step_t;

endpackage

// ===== hdl/sss_in_if.sv =====
// Input channel of the servo settle supervisor: handshake and one item.
interface sss_in_if;
  logic               valid;
  logic               ready;
  logic               tick;
  logic [2:0]         event_code;
  logic               check_position;
  logic signed [15:0] pos_err;

  modport source (
    output valid, tick, event_code, check_position, pos_err,
    input  ready
  );
  modport sink (
    input  valid, tick, event_code, check_position, pos_err,
    output ready
  );
endinterface

// ===== hdl/sss_out_if.sv =====
// Result channel of the servo settle supervisor: handshake and one result.
interface sss_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] state_now;
  logic       changed;
  logic [2:0] state_before;
  logic [7:0] retries;
  logic [2:0] applied_event;
  logic [3:0] reason;

  modport source (
    output valid, state_now, changed, state_before, retries, applied_event, reason,
    input  ready
  );
  modport sink (
    input  valid, state_now, changed, state_before, retries, applied_event, reason,
    output ready
  );
endinterface

// ===== hdl/sss_step.sv =====
// Combinational step of the supervisor: event choice and state transition.
module sss_step (
  input  sss_pkg::item_t item_i,
  input  sss_pkg::cfg_t  cfg_i,
  input  sss_pkg::ctx_t  ctx_i,
  output sss_pkg::step_t step_o
);

  logic [31:0]      time_cnt;
  logic [16:0]      err_mag;
  logic [16:0]      tol_w;
  logic [16:0]      tol2_w;
  logic [7:0]       retry_sat;
  sss_pkg::event_e  ev_code;
  sss_pkg::event_e  ev_derived;
  sss_pkg::event_e  ev;
  sss_pkg::state_e  state_nxt;
  sss_pkg::reason_e reason;
  logic [7:0]       retry_nxt;

  // The tick is counted before the event is chosen.
  assign time_cnt = (item_i.tick && (ctx_i.time_in_state != '1))
                  ? ctx_i.time_in_state + 32'd1 : ctx_i.time_in_state;

  assign err_mag = item_i.pos_err[15]
                 ? 17'h10000 - {1'b0, item_i.pos_err}
                 : {1'b0, item_i.pos_err};

  assign tol_w     = {2'b00, cfg_i.tolerance};
  assign tol2_w    = {1'b0, cfg_i.tolerance, 1'b0};
  assign retry_sat = (ctx_i.retry_cnt != 8'hFF) ? ctx_i.retry_cnt + 8'd1
                                                : ctx_i.retry_cnt;

  // The unused code seven reads as no event.
  always_comb begin
    case (item_i.event_code)
      sss_pkg::EV_START:     ev_code = sss_pkg::EV_START;
      sss_pkg::EV_NEAR:      ev_code = sss_pkg::EV_NEAR;
      sss_pkg::EV_AT_TARGET: ev_code = sss_pkg::EV_AT_TARGET;
      sss_pkg::EV_DRIFT:     ev_code = sss_pkg::EV_DRIFT;
      sss_pkg::EV_TIMEOUT:   ev_code = sss_pkg::EV_TIMEOUT;
      sss_pkg::EV_ERROR:     ev_code = sss_pkg::EV_ERROR;
      default:               ev_code = sss_pkg::EV_NONE;
    endcase
  end

  always_comb begin
    ev_derived = sss_pkg::EV_NONE;
    case (ctx_i.fsm_state)
      sss_pkg::ST_MOVING: begin
        if (err_mag <= tol_w) begin
          ev_derived = sss_pkg::EV_NEAR;
        end else if (time_cnt > cfg_i.move_timeout_ms) begin
          ev_derived = sss_pkg::EV_TIMEOUT;
        end
      end
      sss_pkg::ST_SETTLING: begin
        if (err_mag > tol_w) begin
          ev_derived = sss_pkg::EV_DRIFT;
        end else if (time_cnt >= {16'd0, cfg_i.settle_ms}) begin
          ev_derived = sss_pkg::EV_AT_TARGET;
        end
      end
      sss_pkg::ST_REACHED: begin
        if (err_mag > tol2_w) begin
          ev_derived = sss_pkg::EV_DRIFT;
        end
      end
      default: ev_derived = sss_pkg::EV_NONE;
    endcase
  end

  assign ev = ((ev_code == sss_pkg::EV_NONE) && item_i.check_position) ? ev_derived : ev_code;

  always_comb begin
    state_nxt = ctx_i.fsm_state;
    retry_nxt = ctx_i.retry_cnt;
    reason    = sss_pkg::RS_NONE;
    case (ctx_i.fsm_state)
      sss_pkg::ST_IDLE: begin
        if (ev == sss_pkg::EV_START) begin
          state_nxt = sss_pkg::ST_MOVING;
          retry_nxt = 8'd0;
          reason    = sss_pkg::RS_START;
        end
      end
      sss_pkg::ST_MOVING: begin
        if (ev == sss_pkg::EV_NEAR) begin
          state_nxt = sss_pkg::ST_SETTLING;
          reason    = sss_pkg::RS_NEAR;
        end else if (ev == sss_pkg::EV_TIMEOUT) begin
          state_nxt = sss_pkg::ST_ERROR;
          reason    = sss_pkg::RS_TIMEOUT;
        end else if (ev == sss_pkg::EV_AT_TARGET) begin
          state_nxt = sss_pkg::ST_SETTLING;
          reason    = sss_pkg::RS_AT_TARGET;
        end
      end
      sss_pkg::ST_SETTLING: begin
        if (ev == sss_pkg::EV_AT_TARGET) begin
          // An early arrival report is ignored until the settle time is over.
          if (time_cnt >= {16'd0, cfg_i.settle_ms}) begin
            state_nxt = sss_pkg::ST_REACHED;
            reason    = sss_pkg::RS_STABLE;
          end
        end else if (ev == sss_pkg::EV_DRIFT) begin
          retry_nxt = retry_sat;
          if (retry_sat > cfg_i.retry_limit) begin
            state_nxt = sss_pkg::ST_ERROR;
            reason    = sss_pkg::RS_RETRIES_EXC;
          end else begin
            state_nxt = sss_pkg::ST_MOVING;
            reason    = sss_pkg::RS_DRIFT_RETRY;
          end
        end
      end
      sss_pkg::ST_REACHED: begin
        if (ev == sss_pkg::EV_DRIFT) begin
          state_nxt = sss_pkg::ST_MOVING;
          reason    = sss_pkg::RS_DRIFT;
        end else if (ev == sss_pkg::EV_START) begin
          state_nxt = sss_pkg::ST_MOVING;
          retry_nxt = 8'd0;
          reason    = sss_pkg::RS_NEW_MOVE;
        end
      end
      sss_pkg::ST_ERROR: begin
        if (ev == sss_pkg::EV_START) begin
          state_nxt = sss_pkg::ST_IDLE;
          retry_nxt = 8'd0;
          reason    = sss_pkg::RS_ERROR_RESET;
        end
      end
      default: state_nxt = ctx_i.fsm_state;
    endcase
  end

  always_comb begin
    step_o.ctx.fsm_state     = state_nxt;
    step_o.ctx.retry_cnt     = retry_nxt;
    step_o.applied_event     = ev;
    step_o.reason            = reason;
    step_o.changed           = (state_nxt != ctx_i.fsm_state);
    if (state_nxt != ctx_i.fsm_state) begin
      step_o.ctx.last_state    = ctx_i.fsm_state;
      step_o.ctx.time_in_state = 32'd0;
    end else begin
      step_o.ctx.last_state    = ctx_i.last_state;
      step_o.ctx.time_in_state = time_cnt;
    end
  end

endmodule

// ===== hdl/servo_settle_supervisor_unit.sv =====
// Top level of the servo settle supervisor: channels, registers and state.
// An item transferred in is held in the input register, processed into the result
// register when that is free, and can be transferred out from there. Throughput:
// one item per cycle while results are taken downstream, set by the single pass
// through the step logic.
// Reset (rst_ni low, asynchronous): state idle, counters zero, registers at defaults.
`include "servo_settle_supervisor_unit_defines.svh"

module servo_settle_supervisor_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  sss_in_if.sink                          in_i,
  sss_out_if.source                       out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sss_pkg::AddrWidth-1:0]   paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  // Configuration registers. The register index is the word address, so the
  // low two address bits do not take part in the decode.
  sss_pkg::cfg_t cfg_q;
  logic          cfg_wr;
  sss_pkg::reg_e cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = sss_pkg::reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tolerance       <= sss_pkg::TOLERANCE_RST;
      cfg_q.settle_ms       <= sss_pkg::SETTLE_MS_RST;
      cfg_q.move_timeout_ms <= sss_pkg::MOVE_TIMEOUT_RST;
      cfg_q.retry_limit     <= sss_pkg::RETRY_LIMIT_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        sss_pkg::REG_TOLERANCE:    cfg_q.tolerance       <= pwdata[14:0];
        sss_pkg::REG_SETTLE_MS:    cfg_q.settle_ms       <= pwdata[15:0];
        sss_pkg::REG_MOVE_TIMEOUT: cfg_q.move_timeout_ms <= pwdata;
        sss_pkg::REG_RETRY_LIMIT:  cfg_q.retry_limit     <= pwdata[7:0];
        default:                   cfg_q                 <= cfg_q;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      sss_pkg::REG_TOLERANCE:    prdata = {17'd0, cfg_q.tolerance};
      sss_pkg::REG_SETTLE_MS:    prdata = {16'd0, cfg_q.settle_ms};
      sss_pkg::REG_MOVE_TIMEOUT: prdata = cfg_q.move_timeout_ms;
      sss_pkg::REG_RETRY_LIMIT:  prdata = {24'd0, cfg_q.retry_limit};
      default:                   prdata = 32'd0;
    endcase
  end

  // Two-register pipeline. The input register takes a new transfer whenever it
  // is empty or its item moves on in the same cycle; the result register frees
  // up whenever it is empty or its result is transferred out. So a finished
  // result waiting downstream never blocks the next input transfer by itself.
  logic           in_valid_q;
  sss_pkg::item_t in_item_q;
  logic           out_valid_q;
  sss_pkg::step_t out_step_q;
  logic           out_free;
  logic           advance;
  logic           in_take;

  assign out_free   = !out_valid_q || out_o.ready;
  assign advance    = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.tick           <= in_i.tick;
      in_item_q.event_code     <= in_i.event_code;
      in_item_q.check_position <= in_i.check_position;
      in_item_q.pos_err        <= in_i.pos_err;
    end
  end

  // Supervisor state. It is read and written only by the item that moves from
  // the input register to the result register, so each item sees what the
  // previous one left behind.
  sss_pkg::ctx_t  ctx_q;
  sss_pkg::step_t step;

  sss_step u_step (
    .item_i (in_item_q),
    .cfg_i  (cfg_q),
    .ctx_i  (ctx_q),
    .step_o (step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q.fsm_state     <= sss_pkg::ST_IDLE;
      ctx_q.last_state    <= sss_pkg::ST_IDLE;
      ctx_q.time_in_state <= 32'd0;
      ctx_q.retry_cnt     <= 8'd0;
    end else if (advance) begin
      ctx_q <= step.ctx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_step_q <= step;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.state_now     = out_step_q.ctx.fsm_state;
  assign out_o.changed       = out_step_q.changed;
  assign out_o.state_before  = out_step_q.ctx.last_state;
  assign out_o.retries       = out_step_q.ctx.retry_cnt;
  assign out_o.applied_event = out_step_q.applied_event;
  assign out_o.reason        = out_step_q.reason;

  // A reported transition always names two different states.
  `SSS_ASSERT_NOW(a_changed_states_differ, clk_i, rst_ni,
    out_valid_q && out_step_q.changed, out_o.state_now != out_o.state_before,
    "changed result reports equal states")

  // Any transition restarts the time spent in the state.
  `SSS_ASSERT_NEXT(a_time_cleared_on_change, clk_i, rst_ni,
    advance && step.changed, ctx_q.time_in_state == 32'd0,
    "time in state not cleared on a transition")

  // A move started from idle always begins with no retries.
  `SSS_ASSERT_NOW(a_start_clears_retries, clk_i, rst_ni,
    out_valid_q && (out_step_q.reason == sss_pkg::RS_START), out_o.retries == 8'd0,
    "retry count not cleared on start")

  // The stored state always matches the state of the latest result.
  `SSS_ASSERT_NEXT(a_state_tracks_result, clk_i, rst_ni,
    advance, out_step_q.ctx.fsm_state == ctx_q.fsm_state,
    "result state differs from stored state")

endmodule
